/* sv/rlr_pkg.sv */
// ----------------------------------------------------------------------------
// rlr_pkg
// Shared types and codes for the record log ring.
// ----------------------------------------------------------------------------
package rlr_pkg;

    // Record layout
    localparam int HDR_BYTES = 4;
    localparam int MIN_LEN   = 4;

    // Item functions
    localparam logic [1:0] FN_WRITE_BEGIN = 2'd0;
    localparam logic [1:0] FN_WRITE_BYTE  = 2'd1;
    localparam logic [1:0] FN_READ_BEGIN  = 2'd2;
    localparam logic [1:0] FN_READ_BYTE   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_LEN = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_CLEARED = 3'd3;
    localparam logic [2:0] ST_SEQ     = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] record_len;
        logic [7:0]  data_byte;
        logic [15:0] reader_capacity;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] length;
        logic [7:0]  data_out;
        logic        last;
        logic [12:0] bytes_used;
        logic [9:0]  records_held;
    } t_out;

    // Classified item passed from front to back
    typedef struct packed {
        logic [1:0]  func;
        logic        bad_len;
        logic [15:0] record_len;
        logic [7:0]  data_byte;
        logic [15:0] reader_capacity;
    } t_cmd;

endpackage

/* sv/rlr_stream_if.sv */
// ----------------------------------------------------------------------------
// rlr_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface rlr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/record_log_ring_drop_oldest.sv */
// ----------------------------------------------------------------------------
// record_log_ring_drop_oldest
// Byte ring of length-prefixed log records that drops the oldest when full.
// ----------------------------------------------------------------------------
// Items pass through the 2-beat input queue to the back end. A write_begin
//   first evicts the oldest records one by one, reading each one's two-byte
//   header length from the RAM, and then writes the four header bytes.
// The back end holds one item at a time, as all its steps share the single RAM port.
// Reset: synchronous; pointers, counts and queues clear, ring bytes stay
//   undefined with no clearing pass.
module record_log_ring_drop_oldest #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlr_stream_if.sink   i_in,
    rlr_stream_if.source o_out
);
    logic          w_cmd_valid;
    logic          w_cmd_ready;
    rlr_pkg::t_cmd w_cmd;

    rlr_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    rlr_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_out       (o_out)
    );
endmodule

/* sv/rlr_ram.sv */
// ----------------------------------------------------------------------------
// rlr_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/rlr_front.sv */
// ----------------------------------------------------------------------------
// rlr_front
// Accepts items, checks the write length and queues them for the back end.
// ----------------------------------------------------------------------------
module rlr_front #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rlr_stream_if.sink         i_in,
    output logic               o_cmd_valid,
    output rlr_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_ready
);
    rlr_pkg::t_cmd r_q [2];
    logic          r_wr, n_wr;
    logic          r_rd, n_rd;
    logic [1:0]    r_cnt, n_cnt;
    rlr_pkg::t_cmd w_cmd;
    logic          w_push, w_pop;

    // Classify the incoming beat
    always_comb begin
        w_cmd.func            = i_in.data.func;
        w_cmd.record_len      = i_in.data.record_len;
        w_cmd.data_byte       = i_in.data.data_byte;
        w_cmd.reader_capacity = i_in.data.reader_capacity;
        w_cmd.bad_len = (i_in.data.record_len < 16'(rlr_pkg::MIN_LEN)) ||
                        (17'(i_in.data.record_len) >
                         17'(BUFFER_BYTES - rlr_pkg::HDR_BYTES));
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // Advance queue pointers
    always_comb begin
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = w_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end
endmodule

/* sv/rlr_back.sv */
// ----------------------------------------------------------------------------
// rlr_back
// Executes queued items against the byte ring: eviction walk, header
// writes, payload bytes and reads; drives the result register.
// ----------------------------------------------------------------------------
module rlr_back #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  rlr_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    rlr_stream_if.source  o_out
);
    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int NW = $clog2(BUFFER_BYTES / 8 + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WB_DROP = 4'd1;
    localparam logic [3:0] S_EV0     = 4'd2;
    localparam logic [3:0] S_EV1     = 4'd3;
    localparam logic [3:0] S_EV2     = 4'd4;
    localparam logic [3:0] S_HDR     = 4'd5;
    localparam logic [3:0] S_RB1     = 4'd6;
    localparam logic [3:0] S_RB2     = 4'd7;
    localparam logic [3:0] S_RD1     = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp, r_wa, n_wa;
    logic [CW-1:0] r_used, n_used, r_need, n_need;
    logic [NW-1:0] r_total, n_total;
    logic [15:0]   r_wrem, n_wrem, r_wlen, n_wlen, r_rrem, n_rrem;
    logic [1:0]    r_hcnt, n_hcnt;
    logic          r_last, n_last;
    logic          r_ov, n_ov;
    rlr_pkg::t_out r_od, n_od;
    rlr_pkg::t_cmd r_cmd, n_cmd;
    logic [7:0]    r_lo, n_lo;

    logic          w_out_free, w_over;
    logic          ram_we;
    logic [PW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          e_emit, e_last;
    logic [2:0]    e_status;
    logic [15:0]   e_len, w_hl;
    logic [7:0]    e_data;
    logic [16:0]   w_rec;
    logic [CW-1:0] w_drop;

    // Add with wrap at the ring size; the sum stays below twice the size
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                               input logic [CW-1:0] n);
        logic [PW:0] s;
        s = (PW+1)'(p) + (PW+1)'(n);
        if (s >= (PW+1)'(BUFFER_BYTES)) begin
            s = s - (PW+1)'(BUFFER_BYTES);
        end
        return s[PW-1:0];
    endfunction

    rlr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign w_out_free  = !r_ov || o_out.ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_out_free;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;
    assign w_over = ({1'b0, r_used} + {1'b0, r_need}) > (CW+1)'(BUFFER_BYTES);
    assign w_hl   = {ram_rdata, r_lo};
    assign w_rec  = {1'b0, w_hl} + 17'(rlr_pkg::HDR_BYTES);
    assign w_drop = (18'(r_rrem) > 18'(r_used)) ? r_used : CW'(r_rrem);

    // Sequence one item
    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_wa    = r_wa;
        n_used  = r_used;
        n_need  = r_need;
        n_total = r_total;
        n_wrem  = r_wrem;
        n_wlen  = r_wlen;
        n_rrem  = r_rrem;
        n_hcnt  = r_hcnt;
        n_last  = r_last;
        n_cmd   = r_cmd;
        n_lo    = r_lo;
        ram_we    = 1'b0;
        ram_addr  = r_rp;
        ram_wdata = 8'd0;
        e_emit    = 1'b0;
        e_status  = rlr_pkg::ST_OK;
        e_len     = 16'd0;
        e_data    = 8'd0;
        e_last    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    n_cmd = i_cmd;
                    case (i_cmd.func)
                        rlr_pkg::FN_WRITE_BEGIN: begin
                            if (i_cmd.bad_len) begin
                                e_emit   = 1'b1;
                                e_status = rlr_pkg::ST_BAD_LEN;
                            end else if (r_wrem != 16'd0) begin
                                e_emit   = 1'b1;
                                e_status = rlr_pkg::ST_SEQ;
                            end else begin
                                n_need  = CW'(i_cmd.record_len) +
                                          CW'(rlr_pkg::HDR_BYTES);
                                n_state = S_WB_DROP;
                            end
                        end
                        rlr_pkg::FN_WRITE_BYTE: begin
                            e_emit = 1'b1;
                            if (r_wrem == 16'd0) begin
                                e_status = rlr_pkg::ST_SEQ;
                            end else begin
                                ram_we    = 1'b1;
                                ram_addr  = r_wa;
                                ram_wdata = i_cmd.data_byte;
                                n_wa      = wrap_add(r_wa, CW'(1));
                                n_wrem    = r_wrem - 16'd1;
                                if (r_wrem == 16'd1) begin
                                    // Commit the record
                                    e_last  = 1'b1;
                                    n_used  = r_used + CW'(r_wlen) +
                                              CW'(rlr_pkg::HDR_BYTES);
                                    n_wp    = n_wa;
                                    n_total = r_total + NW'(1);
                                end
                            end
                        end
                        rlr_pkg::FN_READ_BEGIN: begin
                            if (r_rrem != 16'd0) begin
                                e_emit   = 1'b1;
                                e_status = rlr_pkg::ST_SEQ;
                            end else if (r_used < CW'(rlr_pkg::HDR_BYTES) ||
                                         r_total == '0) begin
                                e_emit   = 1'b1;
                                e_status = rlr_pkg::ST_EMPTY;
                            end else begin
                                ram_addr = r_rp;
                                n_state  = S_RB1;
                            end
                        end
                        rlr_pkg::FN_READ_BYTE: begin
                            if (r_rrem == 16'd0 || r_used == '0) begin
                                e_emit   = 1'b1;
                                e_status = rlr_pkg::ST_SEQ;
                                n_rrem   = 16'd0;
                            end else begin
                                ram_addr = r_rp;
                                n_used   = r_used - CW'(1);
                                n_rp     = wrap_add(r_rp, CW'(1));
                                n_rrem   = r_rrem - 16'd1;
                                n_last   = (r_rrem == 16'd1);
                                n_state  = S_RD1;
                            end
                        end
                        default: begin
                            e_emit   = 1'b1;
                            e_status = rlr_pkg::ST_SEQ;
                        end
                    endcase
                end
            end
            S_WB_DROP: begin
                // Drop the unread rest of an open read before evicting
                if (w_over && r_rrem != 16'd0) begin
                    n_used = r_used - w_drop;
                    n_rp   = wrap_add(r_rp, w_drop);
                    n_rrem = 16'd0;
                end
                n_state = S_EV0;
            end
            S_EV0: begin
                if (w_over && r_used != '0) begin
                    ram_addr = r_rp;
                    n_state  = S_EV1;
                end else begin
                    n_wa    = r_wp;
                    n_hcnt  = 2'd0;
                    n_state = S_HDR;
                end
            end
            S_EV1: begin
                n_lo     = ram_rdata;
                ram_addr = wrap_add(r_rp, CW'(1));
                n_state  = S_EV2;
            end
            S_EV2: begin
                if (18'(w_rec) > 18'(r_used)) begin
                    n_used  = '0;
                    n_rp    = r_wp;
                    n_total = '0;
                    n_wa    = r_wp;
                    n_hcnt  = 2'd0;
                    n_state = S_HDR;
                end else begin
                    n_used = r_used - CW'(w_rec);
                    n_rp   = wrap_add(r_rp, CW'(w_rec));
                    if (r_total != '0) begin
                        n_total = r_total - NW'(1);
                    end
                    n_state = S_EV0;
                end
            end
            S_HDR: begin
                ram_we   = 1'b1;
                ram_addr = r_wa;
                case (r_hcnt)
                    2'd0:    ram_wdata = r_cmd.record_len[7:0];
                    2'd1:    ram_wdata = r_cmd.record_len[15:8];
                    2'd2:    ram_wdata = 8'(rlr_pkg::HDR_BYTES);
                    default: ram_wdata = 8'd0;
                endcase
                n_wa   = wrap_add(r_wa, CW'(1));
                n_hcnt = r_hcnt + 2'd1;
                if (r_hcnt == 2'd3) begin
                    n_wlen  = r_cmd.record_len;
                    n_wrem  = r_cmd.record_len;
                    e_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RB1: begin
                n_lo     = ram_rdata;
                ram_addr = wrap_add(r_rp, CW'(1));
                n_state  = S_RB2;
            end
            S_RB2: begin
                e_emit  = 1'b1;
                e_len   = w_hl;
                n_state = S_IDLE;
                if (17'(r_cmd.reader_capacity) < w_rec) begin
                    // Reader too small: clear the whole ring
                    e_status = rlr_pkg::ST_CLEARED;
                    n_wp     = '0;
                    n_rp     = '0;
                    n_used   = '0;
                    n_total  = '0;
                    n_wrem   = 16'd0;
                    n_wlen   = 16'd0;
                    n_rrem   = 16'd0;
                end else begin
                    n_used  = r_used - CW'(rlr_pkg::HDR_BYTES);
                    n_rp    = wrap_add(r_rp, CW'(rlr_pkg::HDR_BYTES));
                    n_total = r_total - NW'(1);
                    n_rrem  = w_hl;
                end
            end
            S_RD1: begin
                e_emit  = 1'b1;
                e_data  = ram_rdata;
                e_last  = r_last;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Load or drain the result register
    always_comb begin
        n_ov = r_ov && !o_out.ready;
        n_od = r_od;
        if (e_emit) begin
            n_ov                 = 1'b1;
            n_od.status          = e_status;
            n_od.length          = e_len;
            n_od.data_out        = e_data;
            n_od.last            = e_last;
            n_od.bytes_used      = 13'(n_used);
            n_od.records_held    = 10'(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_wa    <= '0;
            r_used  <= '0;
            r_need  <= '0;
            r_total <= '0;
            r_wrem  <= 16'd0;
            r_wlen  <= 16'd0;
            r_rrem  <= 16'd0;
            r_hcnt  <= 2'd0;
            r_last  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_wa    <= n_wa;
            r_used  <= n_used;
            r_need  <= n_need;
            r_total <= n_total;
            r_wrem  <= n_wrem;
            r_wlen  <= n_wlen;
            r_rrem  <= n_rrem;
            r_hcnt  <= n_hcnt;
            r_last  <= n_last;
            r_ov    <= n_ov;
        end
    end

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        r_od  <= n_od;
        r_cmd <= n_cmd;
        r_lo  <= n_lo;
    end
endmodule

/* sv/rlr_checker.sv */
// ----------------------------------------------------------------------------
// rlr_checker
// Port-level checks on the result channel of the record log ring.
// ----------------------------------------------------------------------------
module rlr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input rlr_pkg::t_out i_out_data
);
    // Stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // Last flag only on good byte results
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.last |-> i_out_data.status == rlr_pkg::ST_OK &&
        i_out_data.length == 16'd0)
        else $error("last set on a non-byte result");

    // Clearing leaves an empty ring
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == rlr_pkg::ST_CLEARED |->
        i_out_data.bytes_used == 13'd0 && i_out_data.records_held == 10'd0)
        else $error("ring not empty after clear");

    // Data byte only on good results
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.data_out != 8'd0 |->
        i_out_data.status == rlr_pkg::ST_OK && i_out_data.length == 16'd0)
        else $error("data byte on a non-byte result");
endmodule

bind record_log_ring_drop_oldest rlr_checker u_rlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

/* sim/rlr_ring_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlr_ring_checker
// Watches both channels of the record ring, predicts each result beat from
// a private model of the byte ring and compares it field by field.
// ----------------------------------------------------------------------------
module rlr_ring_checker #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  rlr_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  rlr_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);

    // Private copy of the ring
    logic [7:0]    ring_mem [BUFFER_BYTES];
    int            wr_ptr;
    int            rd_ptr;
    int            used;
    int            rec_count;
    int            wr_left;
    int            wr_len;
    int            rd_left;
    rlr_pkg::t_out expected_results[$];

    function automatic int hdr_len_at(int pos);
        return {ring_mem[(pos + 1) % BUFFER_BYTES], ring_mem[pos % BUFFER_BYTES]};
    endfunction

    function automatic void drop_bytes(int n);
        if (n > used) n = used;
        used   -= n;
        rd_ptr  = (rd_ptr + n) % BUFFER_BYTES;
    endfunction

    function automatic void clear_all();
        wr_ptr = 0; rd_ptr = 0; used = 0; rec_count = 0;
        wr_left = 0; wr_len = 0; rd_left = 0;
    endfunction

    // Apply one item to the ring and return the result it should give
    function automatic rlr_pkg::t_out ring_apply(rlr_pkg::t_in it);
        rlr_pkg::t_out r;
        int            need;
        int            rec;
        int            hl;
        r = '0;
        r.status = rlr_pkg::ST_OK;
        case (it.func)
            rlr_pkg::FN_WRITE_BEGIN: begin
                if (it.record_len < rlr_pkg::MIN_LEN ||
                    it.record_len > BUFFER_BYTES - rlr_pkg::HDR_BYTES) begin
                    r.status = rlr_pkg::ST_BAD_LEN;
                end else if (wr_left != 0) begin
                    r.status = rlr_pkg::ST_SEQ;
                end else begin
                    need = it.record_len + rlr_pkg::HDR_BYTES;
                    // drop the rest of an open read before evicting
                    if (used + need > BUFFER_BYTES && rd_left != 0) begin
                        drop_bytes(rd_left);
                        rd_left = 0;
                    end
                    while (used + need > BUFFER_BYTES && used != 0) begin
                        rec = hdr_len_at(rd_ptr) + rlr_pkg::HDR_BYTES;
                        if (rec > used) begin
                            used = 0; rd_ptr = wr_ptr; rec_count = 0;
                            break;
                        end
                        drop_bytes(rec);
                        if (rec_count != 0) rec_count--;
                    end
                    ring_mem[wr_ptr]                      = it.record_len[7:0];
                    ring_mem[(wr_ptr + 1) % BUFFER_BYTES] = it.record_len[15:8];
                    ring_mem[(wr_ptr + 2) % BUFFER_BYTES] = 8'(rlr_pkg::HDR_BYTES);
                    ring_mem[(wr_ptr + 3) % BUFFER_BYTES] = 8'd0;
                    wr_len  = it.record_len;
                    wr_left = it.record_len;
                end
            end
            rlr_pkg::FN_WRITE_BYTE: begin
                if (wr_left == 0) begin
                    r.status = rlr_pkg::ST_SEQ;
                end else begin
                    ring_mem[(wr_ptr + rlr_pkg::HDR_BYTES + wr_len - wr_left) %
                             BUFFER_BYTES] = it.data_byte;
                    wr_left--;
                    // commit the record on its last byte
                    if (wr_left == 0) begin
                        r.last     = 1'b1;
                        used      += wr_len + rlr_pkg::HDR_BYTES;
                        wr_ptr     = (wr_ptr + wr_len + rlr_pkg::HDR_BYTES) % BUFFER_BYTES;
                        rec_count++;
                    end
                end
            end
            rlr_pkg::FN_READ_BEGIN: begin
                if (rd_left != 0) begin
                    r.status = rlr_pkg::ST_SEQ;
                end else if (used < rlr_pkg::HDR_BYTES || rec_count == 0) begin
                    r.status = rlr_pkg::ST_EMPTY;
                end else begin
                    hl       = hdr_len_at(rd_ptr);
                    r.length = 16'(hl);
                    if (int'(it.reader_capacity) < hl + rlr_pkg::HDR_BYTES) begin
                        clear_all();
                        r.status = rlr_pkg::ST_CLEARED;
                    end else begin
                        drop_bytes(rlr_pkg::HDR_BYTES);
                        rec_count--;
                        rd_left = hl;
                    end
                end
            end
            default: begin
                if (rd_left == 0 || used == 0) begin
                    r.status = rlr_pkg::ST_SEQ;
                    rd_left  = 0;
                end else begin
                    r.data_out = ring_mem[rd_ptr];
                    drop_bytes(1);
                    rd_left--;
                    if (rd_left == 0) r.last = 1'b1;
                end
            end
        endcase
        r.bytes_used   = 13'(used);
        r.records_held = 10'(rec_count);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    // Compare result beats, then predict from input beats
    always @(posedge i_clk) begin
        rlr_pkg::t_out exp_r;
        if (!i_rst_n) begin
            clear_all();
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r != i_out_data) begin
                        o_fail_count <= o_fail_count + 1;
                        if (exp_r.status != i_out_data.status)
                            $error("status: expected %0d, got %0d",
                                   exp_r.status, i_out_data.status);
                        if (exp_r.length != i_out_data.length)
                            $error("length: expected %0d, got %0d",
                                   exp_r.length, i_out_data.length);
                        if (exp_r.data_out != i_out_data.data_out)
                            $error("data_out: expected %0d, got %0d",
                                   exp_r.data_out, i_out_data.data_out);
                        if (exp_r.last != i_out_data.last)
                            $error("last: expected %0d, got %0d",
                                   exp_r.last, i_out_data.last);
                        if (exp_r.bytes_used != i_out_data.bytes_used)
                            $error("bytes_used: expected %0d, got %0d",
                                   exp_r.bytes_used, i_out_data.bytes_used);
                        if (exp_r.records_held != i_out_data.records_held)
                            $error("records_held: expected %0d, got %0d",
                                   exp_r.records_held, i_out_data.records_held);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(ring_apply(i_in_data));
        end
    end

endmodule

/* sim/tb_record_log_ring_drop_oldest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_log_ring_drop_oldest
// Drives directed and random record traffic into the log ring with random
// gaps and stalls; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_record_log_ring_drop_oldest;

    localparam int BUFFER_BYTES = 4096;
    localparam int CYCLE_LIMIT  = 3000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   items_sent;
    bit   send_burst;
    bit   recv_burst;
    int   written_lens[$];

    rlr_stream_if #(.t_payload(rlr_pkg::t_in))  in_ch ();
    rlr_stream_if #(.t_payload(rlr_pkg::t_out)) out_ch ();

    record_log_ring_drop_oldest #(.BUFFER_BYTES(BUFFER_BYTES)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    rlr_ring_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: stall at random, with stall-free stretches
    initial begin
        int stall;
        int beats;
        out_ch.ready = 1'b0;
        beats = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 150 == 0) recv_burst = ($urandom_range(0, 3) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            beats++;
        end
    end

    // Send one item, holding valid through back-to-back beats
    task automatic send_item(logic [1:0] fn, int len, int dbyte, int cap);
        rlr_pkg::t_in it;
        int           gap;
        if (items_sent % 120 == 0) send_burst = ($urandom_range(0, 3) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.func            = fn;
        it.record_len      = 16'(len);
        it.data_byte       = 8'(dbyte);
        it.reader_capacity = 16'(cap);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_record(int len);
        send_item(rlr_pkg::FN_WRITE_BEGIN, len, $urandom, $urandom);
        for (int k = 0; k < len; k++)
            send_item(rlr_pkg::FN_WRITE_BYTE, $urandom, $urandom_range(0, 255), $urandom);
        written_lens.push_back(len);
    endtask

    // Read the oldest record as the stimulus side believes it to be
    task automatic read_record(int cap_mode);
        int len;
        int cap;
        len = (written_lens.size() != 0) ? written_lens.pop_front() : 8;
        case (cap_mode)
            0: cap = len + rlr_pkg::HDR_BYTES;
            1: cap = len + rlr_pkg::HDR_BYTES - 1;
            default: cap = $urandom_range(len + rlr_pkg::HDR_BYTES, 65535);
        endcase
        send_item(rlr_pkg::FN_READ_BEGIN, $urandom, $urandom, cap);
        if (cap_mode == 1) begin
            written_lens.delete();
        end else begin
            for (int k = 0; k < len; k++)
                send_item(rlr_pkg::FN_READ_BYTE, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int pick;
        int big_count;
        int rd_part;
        bit paused;
        cycle_count  = 0;
        items_sent   = 0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        i_rst_n      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad lengths, sequence errors, empty, extremes, clearing
        send_item(rlr_pkg::FN_WRITE_BEGIN, 0, 0, 0);
        send_item(rlr_pkg::FN_WRITE_BEGIN, 3, 0, 0);
        send_item(rlr_pkg::FN_WRITE_BEGIN, BUFFER_BYTES - rlr_pkg::HDR_BYTES + 1, 0, 0);
        send_item(rlr_pkg::FN_WRITE_BEGIN, 65535, 255, 65535);
        send_item(rlr_pkg::FN_WRITE_BYTE, 0, 8'hA5, 0);
        send_item(rlr_pkg::FN_READ_BYTE, 0, 0, 0);
        send_item(rlr_pkg::FN_READ_BEGIN, 0, 0, 65535);
        send_item(rlr_pkg::FN_WRITE_BEGIN, rlr_pkg::MIN_LEN, 0, 0);
        send_item(rlr_pkg::FN_WRITE_BEGIN, rlr_pkg::MIN_LEN, 0, 0);
        send_item(rlr_pkg::FN_WRITE_BYTE, 0, 8'h00, 0);
        send_item(rlr_pkg::FN_WRITE_BYTE, 0, 8'hFF, 0);
        send_item(rlr_pkg::FN_WRITE_BYTE, 0, 8'h5A, 0);
        send_item(rlr_pkg::FN_WRITE_BYTE, 0, 8'hC3, 0);
        send_item(rlr_pkg::FN_READ_BEGIN, 0, 0, 0);
        send_item(rlr_pkg::FN_READ_BEGIN, 0, 0, 0);
        written_lens.delete();
        write_record(rlr_pkg::MIN_LEN);
        send_item(rlr_pkg::FN_READ_BEGIN, 0, 0, 65535);
        send_item(rlr_pkg::FN_READ_BEGIN, 0, 0, 65535);
        repeat (rlr_pkg::MIN_LEN) send_item(rlr_pkg::FN_READ_BYTE, 0, 0, 0);
        send_item(rlr_pkg::FN_READ_BYTE, 0, 0, 0);
        written_lens.delete();

        // Random: mostly well-formed records, some noise, a few longer records
        big_count = 0;
        paused    = 1'b0;
        while (items_sent < 600) begin
            pick = $urandom_range(0, 99);
            if (!paused && items_sent > 300) begin
                // let everything drain before going on
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                paused = 1'b1;
            end
            if (pick < 3 && big_count < 2) begin
                big_count++;
                write_record($urandom_range(60, 120));
            end else if (pick < 45) begin
                write_record($urandom_range(rlr_pkg::MIN_LEN, 48));
            end else if (pick < 75) begin
                read_record($urandom_range(0, 9) == 0 ? 1 : $urandom_range(0, 2) * 2);
            end else if (pick < 85) begin
                // open a read and leave part of it for a later eviction
                rd_part = $urandom_range(0, 3);
                send_item(rlr_pkg::FN_READ_BEGIN, 0, 0, 65535);
                repeat (rd_part) send_item(rlr_pkg::FN_READ_BYTE, 0, 0, 0);
                if (written_lens.size() != 0) void'(written_lens.pop_front());
                write_record($urandom_range(rlr_pkg::MIN_LEN, 48));
            end else if (pick < 90) begin
                // abandoned write cut off by a clearing read
                send_item(rlr_pkg::FN_WRITE_BEGIN, $urandom_range(rlr_pkg::MIN_LEN, 30), 0, 0);
                repeat ($urandom_range(0, 3))
                    send_item(rlr_pkg::FN_WRITE_BYTE, 0, $urandom, 0);
                send_item(rlr_pkg::FN_READ_BEGIN, 0, 0, 0);
                written_lens.delete();
            end else begin
                send_item(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                          $urandom_range(0, 255), $urandom_range(0, 65535));
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then let the back end settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
